@@ src/sbc3_pkg.sv @@
// Package for the separable 3x3 basis convolution core.
// Holds widths, the row-result and line-store word types shared by the core and its line RAM.
// No dependencies.
`default_nettype none

package sbc3_pkg;

  // Image geometry.
  localparam int MAX_DIM    = 1024;
  localparam int ADDR_W     = $clog2(MAX_DIM);
  localparam int DIM_W      = 11;
  localparam int PIXEL_W    = 16;
  localparam int ROW_W      = PIXEL_W + 2;
  localparam int OUT_W      = ROW_W + 2;
  localparam int NUM_KERN   = 3;

  // Kernel indexes: sum (1,1,1), p (1,-1,1), q (1,1,-1).
  localparam int K_SUM = 0;
  localparam int K_P   = 1;
  localparam int K_Q   = 2;

  typedef logic signed [PIXEL_W-1:0] pixel_t;
  typedef logic signed [ROW_W-1:0]   row_res_t;
  typedef logic signed [OUT_W-1:0]   out_res_t;
  typedef logic [ADDR_W-1:0]         col_addr_t;

  // Three row results of one row at one column.
  typedef row_res_t [NUM_KERN-1:0] row_set_t;

  // One line-store entry: row results of two rows up and one row up.
  typedef struct packed {
    row_set_t upper;
    row_set_t middle;
  } line_word_t;

  localparam int LINE_W = $bits(line_word_t);

endpackage

`default_nettype wire

@@ src/sbc3_line_ram.sv @@
// Line store RAM for the separable 3x3 basis convolution core.
// One write port and one registered read port, one entry per image column.
// Depends on sbc3_pkg.
`default_nettype none

module sbc3_line_ram
  import sbc3_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rd_en,
  input  wire col_addr_t  rd_addr,
  output line_word_t      rd_data,
  input  wire logic       wr_en,
  input  wire col_addr_t  wr_addr,
  input  wire line_word_t wr_data
);

  line_word_t mem [MAX_DIM];

  // Synchronous read: data is valid in the cycle after the enable.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

@@ src/separable_3x3_basis_convolution_core.sv @@
// Top level of the separable 3x3 basis convolution core.
// Holds the position counters, the left-pixel registers, the compute stage and the output register.
// Depends on sbc3_pkg and sbc3_line_ram.
//
//   Channel | Handshake                | Payload
//   --------+--------------------------+-------------------------------------------
//   input   | in_valid / in_ready      | pixel
//   output  | out_valid / out_ready    | sum_sum .. q_q, last_of_image
//   config  | cfg_wr_en (no wait)      | cfg_wr_data -> image_dim
//
// One pixel is accepted per cycle unless the output stalls. A window result is loaded into the
// output register when the compute stage advances; the RAM read and the stage load on acceptance.
// The line RAM is read when a pixel is accepted and written back by the compute stage.
// Reset clears the counters, the left pixels, image_dim (to 1024) and all valid flags;
// the line RAM needs no clearing. A stalled output holds a producing compute stage and input.
`default_nettype none

module separable_3x3_basis_convolution_core
  import sbc3_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [DIM_W-1:0]   cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pixel_t             pixel,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_res_t                sum_sum,
  output out_res_t                sum_p,
  output out_res_t                sum_q,
  output out_res_t                p_sum,
  output out_res_t                p_p,
  output out_res_t                p_q,
  output out_res_t                q_sum,
  output out_res_t                q_p,
  output out_res_t                q_q,
  output logic                    last_of_image
);

  // Control flags carried with an item into the compute stage.
  typedef struct packed {
    logic      wr;
    logic      produce;
    logic      last;
    col_addr_t col;
  } stage_ctl_t;

  logic [DIM_W-1:0] image_dim;
  col_addr_t        last_idx;
  col_addr_t        col_count;
  col_addr_t        row_count;
  pixel_t           prev_pixel_1;
  pixel_t           prev_pixel_2;

  logic             in_fire;
  logic             s1_valid;
  logic             s1_adv;
  stage_ctl_t       s1_ctl;
  stage_ctl_t       in_ctl;
  pixel_t           s1_a;
  pixel_t           s1_b;
  pixel_t           s1_c;

  line_word_t       rd_word;
  line_word_t       wr_word;
  row_res_t         cur   [NUM_KERN];
  row_res_t         up    [NUM_KERN];
  row_res_t         mid   [NUM_KERN];
  out_res_t         res   [NUM_KERN][NUM_KERN];

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_dim <= DIM_W'(MAX_DIM);
    end else if (cfg_wr_en) begin
      image_dim <= cfg_wr_data;
    end
  end

  // Last column and row index, with the dimension clamped to its legal range.
  always_comb begin
    priority if (image_dim < DIM_W'(3)) begin
      last_idx = ADDR_W'(2);
    end else if (image_dim > DIM_W'(MAX_DIM)) begin
      last_idx = ADDR_W'(MAX_DIM - 1);
    end else begin
      last_idx = ADDR_W'(image_dim - DIM_W'(1));
    end
  end

  // Input handshake: the compute stage is free or moves on this cycle.
  assign s1_adv   = s1_valid && (!s1_ctl.produce || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign in_fire  = in_valid && in_ready;

  // Flags of the item being accepted.
  always_comb begin
    in_ctl.wr      = col_count >= ADDR_W'(2);
    in_ctl.produce = (col_count >= ADDR_W'(2)) && (row_count >= ADDR_W'(2));
    in_ctl.last    = (col_count >= last_idx) && (row_count >= last_idx);
    in_ctl.col     = col_count;
  end

  // Position counters and left-pixel registers advance on each input transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count    <= '0;
      row_count    <= '0;
      prev_pixel_1 <= '0;
      prev_pixel_2 <= '0;
    end else if (in_fire) begin
      prev_pixel_2 <= prev_pixel_1;
      prev_pixel_1 <= pixel;
      if (col_count >= last_idx) begin
        col_count <= '0;
        row_count <= (row_count >= last_idx) ? '0 : row_count + ADDR_W'(1);
      end else begin
        col_count <= col_count + ADDR_W'(1);
      end
    end
  end

  // Compute stage valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Compute stage payload, loaded alongside the line RAM read.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ctl <= in_ctl;
      s1_a   <= prev_pixel_2;
      s1_b   <= prev_pixel_1;
      s1_c   <= pixel;
    end
  end

  // The entry of a column is read again only after at least two more columns have
  // passed, by which time its write-back has been done, so no forwarding is needed.
  sbc3_line_ram u_line_ram (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col_count),
    .rd_data (rd_word),
    .wr_en   (s1_adv && s1_ctl.wr),
    .wr_addr (s1_ctl.col),
    .wr_data (wr_word)
  );

  // Row kernels on the three pixels, then column kernels on the three rows.
  always_comb begin
    cur[K_SUM] = ROW_W'(s1_a) + ROW_W'(s1_b) + ROW_W'(s1_c);
    cur[K_P]   = ROW_W'(s1_a) - ROW_W'(s1_b) + ROW_W'(s1_c);
    cur[K_Q]   = ROW_W'(s1_a) + ROW_W'(s1_b) - ROW_W'(s1_c);
    for (int k = 0; k < NUM_KERN; k++) begin
      up[k]  = rd_word.upper[k];
      mid[k] = rd_word.middle[k];
      res[k][K_SUM] = OUT_W'(up[k]) + OUT_W'(mid[k]) + OUT_W'(cur[k]);
      res[k][K_P]   = OUT_W'(up[k]) - OUT_W'(mid[k]) + OUT_W'(cur[k]);
      res[k][K_Q]   = OUT_W'(up[k]) + OUT_W'(mid[k]) - OUT_W'(cur[k]);
      wr_word.upper[k]  = mid[k];
      wr_word.middle[k] = cur[k];
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_ctl.produce) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (s1_adv && s1_ctl.produce) begin
      sum_sum       <= res[K_SUM][K_SUM];
      sum_p         <= res[K_SUM][K_P];
      sum_q         <= res[K_SUM][K_Q];
      p_sum         <= res[K_P][K_SUM];
      p_p           <= res[K_P][K_P];
      p_q           <= res[K_P][K_Q];
      q_sum         <= res[K_Q][K_SUM];
      q_p           <= res[K_Q][K_P];
      q_q           <= res[K_Q][K_Q];
      last_of_image <= s1_ctl.last;
    end
  end

endmodule

`default_nettype wire
